// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/msm_pkg.sv =====
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types and constants of the multi-stack shared memory block.
// ----------------------------------------------------------------------------
package msm_pkg;

    localparam int MEM_DEPTH_DEF  = 64;
    localparam int MAX_STACKS_DEF = 8;
    localparam int DATA_WIDTH_DEF = 32;

    // Longest run a display may emit.
    localparam int RUN_LIMIT = 64;

    localparam int OP_W      = 2;
    localparam int SN_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 4;
    localparam int SLOTS_W   = 7;
    localparam int FILL_W    = 7;
    localparam int CFG_IDX_W = 1;
    // Address arithmetic: base up to 7*64 plus fill up to 127, compared to MEM_DEPTH.
    localparam int CALC_W    = 11;

    localparam int QUEUE_DEPTH = 2;

    localparam int COUNT_RESET = 1;
    localparam int SLOTS_RESET = 64;

    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_POP     = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADSTACK = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS       = 1'd1;

    typedef enum logic [1:0] {
        CMD_BAD  = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2,
        CMD_DISP = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [SN_W-1:0]      sn;
        logic [CALC_W-1:0]    base;
        logic [SLOTS_W-1:0]   cap;
        logic [VALUE_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic cmd_pop;
        logic disp_busy;
    } back_stat_t;

endpackage

// ===== rtl/msm_front.sv =====
// ----------------------------------------------------------------------------
// msm_front
// Classify an incoming transaction and compute its stack region.
// ----------------------------------------------------------------------------
module msm_front import msm_pkg::*; #(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int MAX_STACKS = MAX_STACKS_DEF
) (
    input  logic [OP_W-1:0]    op,
    input  logic [SN_W-1:0]    sn,
    input  logic [VALUE_W-1:0] value,
    input  logic [CNT_W-1:0]   stack_count,
    input  logic [SLOTS_W-1:0] slots,
    output logic               drop,
    output cmd_t               cmd
);

    localparam int CAP_LIMIT = (MEM_DEPTH < RUN_LIMIT) ? MEM_DEPTH : RUN_LIMIT;

    logic [6:0]           eff_count;
    logic [SLOTS_W-1:0]   eff_cap;
    logic [SN_W+SLOTS_W-1:0] product;

    always_comb begin
        eff_count = ({3'b0, stack_count} > 7'(MAX_STACKS)) ? 7'(MAX_STACKS)
                                                            : {3'b0, stack_count};
        eff_cap   = (slots > SLOTS_W'(CAP_LIMIT)) ? SLOTS_W'(CAP_LIMIT) : slots;
        product   = {{SLOTS_W{1'b0}}, sn} * {{SN_W{1'b0}}, eff_cap};

        drop      = 1'b0;
        cmd.sn    = sn;
        cmd.base  = CALC_W'(product);
        cmd.cap   = eff_cap;
        cmd.value = value;
        cmd.kind  = CMD_BAD;
        case (op)
            OP_PUSH:    cmd.kind = CMD_PUSH;
            OP_POP:     cmd.kind = CMD_POP;
            OP_DISPLAY: cmd.kind = CMD_DISP;
            default:    drop = 1'b1;
        endcase
        if ({4'b0, sn} >= eff_count) begin
            cmd.kind = CMD_BAD;
        end
    end

endmodule

// ===== rtl/msm_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// msm_cmd_queue
// Short command queue between the front classifier and the back engine.
// ----------------------------------------------------------------------------
module msm_cmd_queue import msm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/msm_back.sv =====
// ----------------------------------------------------------------------------
// msm_back
// Execute stack commands against the shared element memory.
// ----------------------------------------------------------------------------
module msm_back import msm_pkg::*; #(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int MAX_STACKS = MAX_STACKS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output back_stat_t          stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [VALUE_W-1:0]  m_tdata,
    output logic [STATUS_W-1:0] m_tuser,
    output logic                m_tlast
);

    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int FILL_DEPTH = (MAX_STACKS < (1 << SN_W)) ? MAX_STACKS : (1 << SN_W);
    localparam int FIDX_W     = (FILL_DEPTH > 1) ? $clog2(FILL_DEPTH) : 1;
    localparam logic [CALC_W-1:0] MEM_LIM = CALC_W'(MEM_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DISP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [FILL_W-1:0]     fill_reg [FILL_DEPTH];
    logic                  fill_we;
    logic [FIDX_W-1:0]     fill_idx;
    logic [FILL_W-1:0]     fill_cur, fill_wdata;

    logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
    logic                  mem_we, rd_en, rd_wanted;
    logic [DATA_WIDTH-1:0] mem_wdata, rd_data_reg;
    logic [CALC_W-1:0]     rd_calc;

    logic [CALC_W-1:0]     disp_base_reg, disp_base_next;
    logic [FILL_W-1:0]     disp_j_reg, disp_j_next;
    logic [FILL_W-1:0]     disp_n_reg, disp_n_next;

    logic                  r_valid_reg, r_valid_next;
    logic [STATUS_W-1:0]   r_status_reg, r_status_next;
    logic                  r_last_reg, r_last_next;
    logic                  r_mem_reg, r_mem_next;

    logic                  m_valid_reg;
    logic [VALUE_W-1:0]    m_data_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic                  m_last_reg;

    logic                  m_free, r_adv, issue_ok, take;
    logic                  emit, emit_last;
    logic [STATUS_W-1:0]   emit_status;
    logic [CALC_W-1:0]     push_addr, pop_addr, disp_addr;
    logic [FILL_W-1:0]     run_len;
    logic [DATA_WIDTH+VALUE_W-1:0] wr_ext, rd_ext;

    assign m_free   = !m_valid_reg || m_tready;
    assign r_adv    = r_valid_reg && m_free;
    assign issue_ok = !r_valid_reg || m_free;

    assign fill_idx  = cmd.sn[FIDX_W-1:0];
    assign fill_cur  = fill_reg[fill_idx];
    assign push_addr = cmd.base + CALC_W'(fill_cur);
    assign pop_addr  = push_addr - 1'b1;
    assign disp_addr = disp_base_reg + CALC_W'(disp_j_reg);
    assign run_len   = (fill_cur > FILL_W'(RUN_LIMIT)) ? FILL_W'(RUN_LIMIT) : fill_cur;

    // Pushed value keeps its low bits; read value is sign extended.
    assign wr_ext    = {{DATA_WIDTH{1'b0}}, cmd.value};
    assign mem_wdata = wr_ext[DATA_WIDTH-1:0];
    assign rd_ext    = {{VALUE_W{rd_data_reg[DATA_WIDTH-1]}}, rd_data_reg};

    always_comb begin
        state_next     = state_reg;
        take           = 1'b0;
        fill_we        = 1'b0;
        fill_wdata     = fill_cur;
        mem_we         = 1'b0;
        rd_wanted      = 1'b0;
        rd_calc        = disp_addr;
        emit           = 1'b0;
        emit_status    = ST_OK;
        emit_last      = 1'b1;
        disp_base_next = disp_base_reg;
        disp_j_next    = disp_j_reg;
        disp_n_next    = disp_n_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && issue_ok) begin
                    take = 1'b1;
                    emit = 1'b1;
                    case (cmd.kind)
                        CMD_BAD: begin
                            emit_status = ST_BADSTACK;
                        end
                        CMD_PUSH: begin
                            if (fill_cur >= cmd.cap || push_addr >= MEM_LIM) begin
                                emit_status = ST_OVERFLOW;
                            end else begin
                                mem_we     = 1'b1;
                                fill_we    = 1'b1;
                                fill_wdata = fill_cur + 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (fill_cur == '0) begin
                                emit_status = ST_EMPTY;
                            end else begin
                                fill_we    = 1'b1;
                                fill_wdata = fill_cur - 1'b1;
                                rd_wanted  = 1'b1;
                                rd_calc    = pop_addr;
                            end
                        end
                        CMD_DISP: begin
                            if (fill_cur == '0) begin
                                emit_status = ST_EMPTY;
                            end else begin
                                rd_wanted      = 1'b1;
                                rd_calc        = cmd.base;
                                disp_base_next = cmd.base;
                                disp_n_next    = run_len;
                                disp_j_next    = FILL_W'(1);
                                emit_last      = (run_len == FILL_W'(1));
                                if (run_len != FILL_W'(1)) begin
                                    state_next = S_DISP;
                                end
                            end
                        end
                        default: begin
                            emit_status = ST_BADSTACK;
                        end
                    endcase
                end
            end
            S_DISP: begin
                if (issue_ok) begin
                    emit        = 1'b1;
                    rd_wanted   = 1'b1;
                    emit_last   = (disp_j_reg + 1'b1 == disp_n_reg);
                    disp_j_next = disp_j_reg + 1'b1;
                    if (disp_j_reg + 1'b1 == disp_n_reg) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_en = rd_wanted && (rd_calc < MEM_LIM);

    always_comb begin
        r_valid_next  = r_valid_reg;
        r_status_next = r_status_reg;
        r_last_next   = r_last_reg;
        r_mem_next    = r_mem_reg;
        if (emit) begin
            r_valid_next  = 1'b1;
            r_status_next = emit_status;
            r_last_next   = emit_last;
            r_mem_next    = rd_en;
        end else if (r_adv) begin
            r_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            r_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < FILL_DEPTH; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            r_valid_reg <= r_valid_next;
            if (fill_we) begin
                fill_reg[fill_idx] <= fill_wdata;
            end
            if (r_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        disp_base_reg <= disp_base_next;
        disp_j_reg    <= disp_j_next;
        disp_n_reg    <= disp_n_next;
        r_status_reg  <= r_status_next;
        r_last_reg    <= r_last_next;
        r_mem_reg     <= r_mem_next;
        if (r_adv) begin
            m_data_reg   <= r_mem_reg ? rd_ext[VALUE_W-1:0] : '0;
            m_status_reg <= r_status_reg;
            m_last_reg   <= r_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[push_addr[AW-1:0]] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_calc[AW-1:0]];
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign m_tdata        = m_data_reg;
    assign m_tuser        = m_status_reg;
    assign m_tlast        = m_last_reg;
    assign stat.cmd_pop   = take;
    assign stat.disp_busy = (state_reg == S_DISP);

endmodule

// ===== rtl/multi_stack_shared_memory.sv =====
// ----------------------------------------------------------------------------
// multi_stack_shared_memory
// Several LIFO stacks carved out of one shared element memory.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries commands: tuser selects push, pop or display and the
//   stack; tdata carries the value to push. Master stream returns results:
//   tuser is the status, tdata the popped or displayed element, tlast marks
//   the final result of a command. Every command but an unknown opcode gives
//   at least one result; display of a non-empty stack gives one per element.
//   Path: an accepted command passes the command queue, then the read stage,
//   then the output register, before its first result is valid.
//   Throughput: one command per cycle for push, pop and error cases while the
//   receiver does not stall; a display holds the engine until its last element
//   is emitted. The engine takes one command at a time.
//   Reset clears the fill counts, the queue and the output; stack_count
//   resets to 1 and slots_per_stack to 64. Element memory is not cleared.
//   When the receiver stalls, results hold in the output and read stages,
//   the engine then holds, and the command queue fills before s_tready drops.
//   Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_stack_shared_memory import msm_pkg::*; #(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int MAX_STACKS = MAX_STACKS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_W-1:0]    s_tdata,   // [31:0] value
    input  logic [OP_W+SN_W-1:0]  s_tuser,   // [1:0] operation, [4:2] stack_number
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VALUE_W-1:0]    m_tdata,   // [31:0] data
    output logic [STATUS_W-1:0]   m_tuser,   // [1:0] status
    output logic                  m_tlast,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [SLOTS_W-1:0]    cfg_wdata
);

    logic [CNT_W-1:0]   stack_count_reg;
    logic [SLOTS_W-1:0] slots_reg;

    logic       front_drop;
    cmd_t       front_cmd;
    logic       q_full, q_wr, q_valid;
    cmd_t       q_cmd;
    back_stat_t back_stat;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_count_reg <= CNT_W'(COUNT_RESET);
            slots_reg       <= SLOTS_W'(SLOTS_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_STACK_COUNT: stack_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_SLOTS:       slots_reg       <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Front: classify the transaction, compute region base and capacity.
    msm_front #(
        .MEM_DEPTH  (MEM_DEPTH),
        .MAX_STACKS (MAX_STACKS)
    ) u_front (
        .op          (s_tuser[OP_W-1:0]),
        .sn          (s_tuser[OP_W+SN_W-1:OP_W]),
        .value       (s_tdata),
        .stack_count (stack_count_reg),
        .slots       (slots_reg),
        .drop        (front_drop),
        .cmd         (front_cmd)
    );

    // Accept whenever the queue has room; drop unknown opcodes here.
    assign s_tready = !q_full;
    assign q_wr     = s_tvalid && s_tready && !front_drop;

    msm_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr),
        .wr_cmd   (front_cmd),
        .full     (q_full),
        .rd_en    (back_stat.cmd_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    // Back: fill counts, element memory, read stage and output register.
    msm_back #(
        .MEM_DEPTH  (MEM_DEPTH),
        .MAX_STACKS (MAX_STACKS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .stat      (back_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // The engine never takes a command from an empty queue.
    `ASSERT_NEVER(a_pop_from_empty, aclk, aresetn, back_stat.cmd_pop && !q_valid)
    // Error and empty results always close their run.
    `ASSERT_AT(a_err_is_last, aclk, aresetn, (m_tvalid && (m_tuser != ST_OK)) |-> m_tlast)
    // No new command is taken while a display run is streaming.
    `ASSERT_AT(a_disp_blocks_pop, aclk, aresetn, back_stat.disp_busy |-> !back_stat.cmd_pop)

endmodule

// ===== dv/multi_stack_shared_memory_tb.sv =====
// ----------------------------------------------------------------------------
// multi_stack_shared_memory_tb
// Self-checking bench for the shared-memory stack block: a directed table of
// commands and register writes, then random phases under varied stack counts
// and capacities, scored against an in-bench model of the stacks or a typed result.
// ----------------------------------------------------------------------------
module multi_stack_shared_memory_tb;
    import msm_pkg::*;

    // Opcode the block must swallow without a result.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_PHASES     = 10;
    localparam int RANDOM_ITEMS   = PHASE_ITEMS * NUM_PHASES;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_GAP        = 30;
    localparam int MAX_STALL      = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SN_W-1:0]    sn;
        logic [VALUE_W-1:0] value;
    } stack_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic                last;
    } stack_res_t;

    // ROW_FIXED rows carry a single typed result; ROW_CMD rows are scored by
    // the model alone; ROW_CFG rows write a register.
    typedef enum {ROW_CMD, ROW_FIXED, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  creg;
        logic [SLOTS_W-1:0]    cval;
        logic [OP_W-1:0]       op;
        logic [SN_W-1:0]       sn;
        logic [VALUE_W-1:0]    value;
        logic [STATUS_W-1:0]   st;
        logic [VALUE_W-1:0]    dat;
    } directed_row_t;

    localparam int NUM_DIRECTED = 29;

    directed_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        // Empty stack right after reset, and the reset stack count of one.
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_POP,     3'd0, 32'h0,        ST_EMPTY,    32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_DISPLAY, 3'd0, 32'h0,        ST_EMPTY,    32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd1, 32'h5,        ST_BADSTACK, 32'h0},
        // Value extremes.
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd0, 32'h7FFFFFFF, ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd0, 32'h80000000, ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd0, 32'hFFFFFFFF, ST_OK,       32'h0},
        '{ROW_CMD,   REG_STACK_COUNT, 7'd0, OP_DISPLAY, 3'd0, 32'h0,        ST_OK,       32'h0},
        '{ROW_CMD,   REG_STACK_COUNT, 7'd0, OP_UNKNOWN, 3'd0, 32'hDEADBEEF, ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_POP,     3'd0, 32'h0,        ST_OK,       32'hFFFFFFFF},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_POP,     3'd7, 32'h0,        ST_BADSTACK, 32'h0},
        // Shrink capacity below the fill of stack 0.
        '{ROW_CFG,   REG_STACK_COUNT, 7'd8, OP_PUSH,    3'd0, 32'h0,        ST_OK,       32'h0},
        '{ROW_CFG,   REG_SLOTS,       7'd1, OP_PUSH,    3'd0, 32'h0,        ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd0, 32'h0,        ST_OVERFLOW, 32'h0},
        '{ROW_CMD,   REG_STACK_COUNT, 7'd0, OP_DISPLAY, 3'd0, 32'h0,        ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd7, 32'h12345678, ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd7, 32'hA5A5A5A5, ST_OVERFLOW, 32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_POP,     3'd7, 32'h0,        ST_OK,       32'h12345678},
        // Regions that run past the end of memory.
        '{ROW_CFG,   REG_SLOTS,       7'd40, OP_PUSH,   3'd0, 32'h0,        ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd1, 32'h5A5A5A5A, ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd2, 32'h1,        ST_OVERFLOW, 32'h0},
        '{ROW_CFG,   REG_SLOTS,       7'd127, OP_PUSH,  3'd0, 32'h0,        ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_DISPLAY, 3'd1, 32'h0,        ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_POP,     3'd1, 32'h0,        ST_OK,       32'h0},
        // Zero stacks (upper write bits must be dropped), then too many stacks.
        '{ROW_CFG,   REG_STACK_COUNT, 7'h70, OP_PUSH,   3'd0, 32'h0,        ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_DISPLAY, 3'd0, 32'h0,        ST_BADSTACK, 32'h0},
        '{ROW_CFG,   REG_STACK_COUNT, 7'd15, OP_PUSH,   3'd0, 32'h0,        ST_OK,       32'h0},
        // Zero capacity: every push overflows, pops still reach old data.
        '{ROW_CFG,   REG_SLOTS,       7'd0, OP_PUSH,    3'd0, 32'h0,        ST_OK,       32'h0},
        '{ROW_FIXED, REG_STACK_COUNT, 7'd0, OP_PUSH,    3'd7, 32'h0,        ST_OVERFLOW, 32'h0},
        '{ROW_CMD,   REG_STACK_COUNT, 7'd0, OP_POP,     3'd0, 32'h0,        ST_OK,       32'h0}
    };

    // Register settings of the random phases: {stack_count, slots_per_stack}.
    int phase_count [0:NUM_PHASES-1] = '{8, 4, 3, 15, 1, 0, 2, 5, 6, 1};
    int phase_slots [0:NUM_PHASES-1] = '{8, 16, 127, 13, 1, 5, 64, 0, 10, 64};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata   = '0;
    logic [OP_W+SN_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [VALUE_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [SLOTS_W-1:0]    cfg_wdata = '0;

    // Shadow copy of the stacks and their registers.
    logic [VALUE_W-1:0]    elem_mem    [MEM_DEPTH_DEF];
    bit                    elem_valid  [MEM_DEPTH_DEF];
    logic [FILL_W-1:0]     fill_cnt    [MAX_STACKS_DEF];
    logic [CNT_W-1:0]      stack_count_reg = 4'(COUNT_RESET);
    logic [SLOTS_W-1:0]    slots_reg       = 7'(SLOTS_RESET);

    stack_res_t            step_results[$];     // results of the latest command
    stack_res_t            stack_results_q[$];  // results still owed by the block
    stack_res_t            got_res;
    stack_res_t            want_res;

    int                    errors        = 0;
    int                    src_idle_pct  = 22;
    int                    dst_idle_pct  = 79;
    int                    stall_run     = 0;
    int                    quiet_cycles  = 0;

    multi_stack_shared_memory u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Stack count and capacity as the block applies them.
    function automatic int active_stacks();
        return (stack_count_reg > MAX_STACKS_DEF) ? MAX_STACKS_DEF : int'(stack_count_reg);
    endfunction

    function automatic int stack_capacity();
        int cap;
        cap = int'(slots_reg);
        if (cap > RUN_LIMIT)
            cap = RUN_LIMIT;
        if (cap > MEM_DEPTH_DEF)
            cap = MEM_DEPTH_DEF;
        return cap;
    endfunction

    // Addresses past the end of memory read back as zero.
    function automatic logic [VALUE_W-1:0] read_elem(int addr);
        return (addr >= MEM_DEPTH_DEF) ? '0 : elem_mem[addr];
    endfunction

    // Advance the shadow stacks by one command and collect its results.
    function automatic void apply_stack_op(stack_cmd_t c);
        int cap, base, fill, addr, n;
        step_results.delete();
        if (c.op == OP_UNKNOWN)
            return;
        if (c.sn >= active_stacks()) begin
            step_results.push_back('{ST_BADSTACK, '0, 1'b1});
            return;
        end
        cap  = stack_capacity();
        base = int'(c.sn) * cap;
        fill = int'(fill_cnt[c.sn]);
        if (c.op == OP_PUSH) begin
            addr = base + fill;
            if (fill >= cap || addr >= MEM_DEPTH_DEF) begin
                step_results.push_back('{ST_OVERFLOW, '0, 1'b1});
            end else begin
                elem_mem[addr]   = c.value;
                elem_valid[addr] = 1'b1;
                fill_cnt[c.sn]   = 7'(fill + 1);
                step_results.push_back('{ST_OK, '0, 1'b1});
            end
        end else if (fill == 0) begin
            step_results.push_back('{ST_EMPTY, '0, 1'b1});
        end else if (c.op == OP_POP) begin
            fill_cnt[c.sn] = 7'(fill - 1);
            step_results.push_back('{ST_OK, read_elem(base + fill - 1), 1'b1});
        end else begin
            n = (fill > RUN_LIMIT) ? RUN_LIMIT : fill;
            for (int j = 0; j < n; j++)
                step_results.push_back('{ST_OK, read_elem(base + j), 1'(j == n - 1)});
        end
    endfunction

    // Offer one command, hold it until the transaction completes, then book
    // what it owes. A fixed row replaces the model's answer by its own.
    task automatic send_cmd(input stack_cmd_t c, input bit fixed, input stack_res_t typed);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {c.sn, c.op};
        s_tdata  <= c.value;
        do @(posedge aclk); while (!s_tready);
        apply_stack_op(c);
        if (fixed) begin
            step_results.delete();
            step_results.push_back(typed);
        end
        foreach (step_results[k])
            stack_results_q.push_back(step_results[k]);
    endtask

    // Write a register once the block has gone quiet: drop valid, let every
    // owed result drain, then give in-flight unknown opcodes time to retire.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SLOTS_W-1:0] val);
        s_tvalid <= 1'b0;
        while (stack_results_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_STACK_COUNT)
            stack_count_reg = val[CNT_W-1:0];
        else
            slots_reg = val;
    endtask

    // Receiver: stall at the current rate, but never longer than MAX_STALL.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_run <= 0;
        end else if (stall_run < MAX_STALL && $urandom_range(99) < dst_idle_pct) begin
            m_tready  <= 1'b0;
            stall_run <= stall_run + 1;
        end else begin
            m_tready  <= 1'b1;
            stall_run <= 0;
        end
    end

    // Score every result transaction against the oldest owed result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = '{m_tuser, m_tdata, m_tlast};
            if (stack_results_q.size() == 0) begin
                $display("%0t: unexpected result: status=%0d data=%h last=%b",
                         $time, got_res.status, got_res.data, got_res.last);
                errors++;
            end else begin
                want_res = stack_results_q.pop_front();
                if (got_res !== want_res) begin
                    $display("%0t: result mismatch: expected status=%0d data=%h last=%b, actual status=%0d data=%h last=%b",
                             $time, want_res.status, want_res.data, want_res.last,
                             got_res.status, got_res.data, got_res.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        stack_cmd_t    cmd;
        directed_row_t row;
        int            roll, base, depth, lo, hi, item_no;

        foreach (fill_cnt[i])
            fill_cnt[i] = '0;
        foreach (elem_valid[i])
            elem_valid[i] = 1'b0;

        // Hold reset, then release it on a rising edge.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_reg(row.creg, row.cval);
            else
                send_cmd('{row.op, row.sn, row.value}, row.kind == ROW_FIXED,
                         '{row.st, row.dat, 1'b1});
        end

        // Random phases, each under a fresh register setting.
        item_no = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            // Set random upper bits on the count write; the block must drop them.
            write_reg(REG_STACK_COUNT, {3'($urandom_range(7)), 4'(phase_count[p])});
            write_reg(REG_SLOTS, 7'(phase_slots[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Swap the idling sides after a third, stop idling after two.
                if (item_no == RANDOM_ITEMS / 3) begin
                    src_idle_pct = 79;
                    dst_idle_pct = 22;
                end else if (item_no == 2 * RANDOM_ITEMS / 3) begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
                item_no++;

                cmd.value = $urandom();
                roll = $urandom_range(99);
                cmd.op = (roll < 45) ? OP_PUSH : (roll < 70) ? OP_POP :
                         (roll < 93) ? OP_DISPLAY : OP_UNKNOWN;
                // Mostly in-range stacks; now and then any number at all.
                if (active_stacks() > 0 && $urandom_range(9) != 0)
                    cmd.sn = 3'($urandom_range(active_stacks() - 1));
                else
                    cmd.sn = 3'($urandom_range(7));

                // Turn into a push any read that would touch a never-written entry.
                if ((cmd.op == OP_POP || cmd.op == OP_DISPLAY) && cmd.sn < active_stacks()
                        && fill_cnt[cmd.sn] != 0) begin
                    base  = int'(cmd.sn) * stack_capacity();
                    depth = int'(fill_cnt[cmd.sn]);
                    lo    = (cmd.op == OP_POP) ? base + depth - 1 : base;
                    hi    = base + ((depth > RUN_LIMIT) ? RUN_LIMIT : depth);
                    for (int a = lo; a < hi; a++)
                        if (a < MEM_DEPTH_DEF && !elem_valid[a])
                            cmd.op = OP_PUSH;
                end

                send_cmd(cmd, 1'b0, '0);
            end
        end

        // Drain: let every owed result arrive, then watch for strays.
        s_tvalid <= 1'b0;
        while (stack_results_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && stack_results_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
